@@ rtl/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared constants and types of the Pearson correlation block.
// ----------------------------------------------------------------------------
package pcc_pkg;

	// field widths of one beat
	localparam int FIELD_W   = 16;
	localparam int COEF_W    = 16;

	// fraction bits of the coefficient and bits of its magnitude
	localparam int FRAC_BITS = 14;
	localparam int QB        = FRAC_BITS + 1;

	// defaults of the top level parameters
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int VECTOR_LENGTH_DEF = 6;

	// sign and zero-variance marks that travel with an item
	typedef struct packed {
		logic deg;
		logic neg;
	} pcc_flags_t;

endpackage

@@ rtl/pcc_lane.sv @@
// ----------------------------------------------------------------------------
// pcc_lane
// One element lane: decodes an x/y sample pair and registers its products.
// ----------------------------------------------------------------------------
module pcc_lane import pcc_pkg::*; #(
	parameter int SW = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic        [FIELD_W-1:0]  x,
	input  logic        [FIELD_W-1:0]  y,
	output logic signed [SW-1:0]       x_s1,
	output logic signed [SW-1:0]       y_s1,
	output logic signed [2*SW-1:0]     xy_s1,
	output logic signed [2*SW-1:0]     xx_s1,
	output logic signed [2*SW-1:0]     yy_s1
);

	logic signed [SW-1:0]   xd;
	logic signed [SW-1:0]   yd;
	logic signed [2*SW-1:0] xy_c;
	logic signed [2*SW-1:0] xx_c;
	logic signed [2*SW-1:0] yy_c;

	// take the low sample bits as a signed value
	assign xd = $signed(x[SW-1:0]);
	assign yd = $signed(y[SW-1:0]);

	// form the three products of this element
	assign xy_c = xd * yd;
	assign xx_c = xd * xd;
	assign yy_c = yd * yd;

	// hold the lane results for the merge stage
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= xd;
			y_s1  <= yd;
			xy_s1 <= xy_c;
			xx_s1 <= xx_c;
			yy_s1 <= yy_c;
		end
	end

endmodule

@@ rtl/pcc_wide_mul.sv @@
// ----------------------------------------------------------------------------
// pcc_wide_mul
// Two-stage unsigned multiplier: half-width partial products, then their sum.
// ----------------------------------------------------------------------------
module pcc_wide_mul #(
	parameter int W = 42
) (
	input  logic           clk,
	input  logic           en1,
	input  logic           en2,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p_s2
);

	localparam int H  = (W + 1) / 2;
	localparam int HW = W - H;

	logic [2*H-1:0]  ll_s1;
	logic [W-1:0]    lh_s1;
	logic [W-1:0]    hl_s1;
	logic [2*HW-1:0] hh_s1;
	logic [2*W-1:0]  sum_c;

	// form the four partial products
	always_ff @(posedge clk) begin
		if (en1) begin
			ll_s1 <= a[H-1:0] * b[H-1:0];
			lh_s1 <= W'(a[H-1:0]) * W'(b[W-1:H]);
			hl_s1 <= W'(a[W-1:H]) * W'(b[H-1:0]);
			hh_s1 <= (2*HW)'(a[W-1:H]) * (2*HW)'(b[W-1:H]);
		end
	end

	// align and add the partial products
	assign sum_c = (2*W)'(ll_s1) + ((2*W)'(lh_s1) << H) + ((2*W)'(hl_s1) << H)
		+ ((2*W)'(hh_s1) << (2*H));

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= sum_c;
		end
	end

endmodule

@@ rtl/pcc_root_step.sv @@
// ----------------------------------------------------------------------------
// pcc_root_step
// One bit of the coefficient magnitude: largest q with q^2 * P <= M.
// Keeps the remainder R = M - q^2*P and A = q*P so a step is shift, add,
// compare and subtract only.
// ----------------------------------------------------------------------------
module pcc_root_step import pcc_pkg::*; #(
	parameter int PW = 84,
	parameter int RW = 115,
	parameter int K  = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [RW-1:0]    r_i,
	input  logic [RW-1:0]    a_i,
	input  logic [PW-1:0]    p_i,
	input  logic [QB-1:0]    q_i,
	input  pcc_flags_t       f_i,
	output logic [RW-1:0]    r_q,
	output logic [RW-1:0]    a_q,
	output logic [PW-1:0]    p_q,
	output logic [QB-1:0]    q_q,
	output pcc_flags_t       f_q
);

	logic [RW-1:0] p_ext;
	logic [RW-1:0] t_c;
	logic          take;

	// cost of setting bit K: (2q*2^K + 2^2K) * P
	assign p_ext = RW'(p_i);
	assign t_c   = (a_i << (K + 1)) + (p_ext << (2 * K));
	assign take  = (t_c <= r_i);

	// keep the bit when it fits and advance the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= take ? (r_i - t_c) : r_i;
			a_q <= take ? (a_i + (p_ext << K)) : a_i;
			q_q <= take ? (q_i | (QB'(1) << K)) : q_i;
			p_q <= p_i;
			f_q <= f_i;
		end
	end

endmodule

@@ rtl/pearson_correlation_six_top.sv @@
// ----------------------------------------------------------------------------
// pearson_correlation_six_top
// Pearson correlation of two short sample vectors, signed Q1.14 result.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir
//  item     | item_valid, item_ready, x_0..x_5, y_0..y_5 | in
//  result   | result_valid, result_ready, coefficient,   | out
//           | degenerate                                 |
//
//  One beat is accepted every cycle while item_ready is high; the stages are
//  lanes, merge, variance, two-stage wide multiply and fifteen root bit stages.
//  Each stage advances when it is empty or the next stage advances, so the
//  pipe keeps filling while a result waits at the output.
//  Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module pearson_correlation_six_top import pcc_pkg::*; #(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  logic        [FIELD_W-1:0] x_0,
	input  logic        [FIELD_W-1:0] x_1,
	input  logic        [FIELD_W-1:0] x_2,
	input  logic        [FIELD_W-1:0] x_3,
	input  logic        [FIELD_W-1:0] x_4,
	input  logic        [FIELD_W-1:0] x_5,
	input  logic        [FIELD_W-1:0] y_0,
	input  logic        [FIELD_W-1:0] y_1,
	input  logic        [FIELD_W-1:0] y_2,
	input  logic        [FIELD_W-1:0] y_3,
	input  logic        [FIELD_W-1:0] y_4,
	input  logic        [FIELD_W-1:0] y_5,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [COEF_W-1:0] coefficient,
	output logic                     degenerate
);

	localparam int L    = VECTOR_LENGTH;
	localparam int SW   = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
	localparam int LB   = $clog2(L + 1);
	localparam int SXW  = SW + LB;
	localparam int PRW  = 2 * SW + LB;
	localparam int NW   = 2 * SW + 2 * LB + 4;
	localparam int PW   = 2 * NW;
	localparam int RW   = PW + 31;
	localparam int NST  = 5 + QB;

	localparam logic signed [NW-1:0] N_S = NW'(L);

	// stage valids and advance enables
	logic [NST-1:0] valid_q;
	logic [NST-1:0] en;

	// input fields as arrays
	logic [FIELD_W-1:0] xin [6];
	logic [FIELD_W-1:0] yin [6];

	assign xin[0] = x_0;
	assign xin[1] = x_1;
	assign xin[2] = x_2;
	assign xin[3] = x_3;
	assign xin[4] = x_4;
	assign xin[5] = x_5;
	assign yin[0] = y_0;
	assign yin[1] = y_1;
	assign yin[2] = y_2;
	assign yin[3] = y_3;
	assign yin[4] = y_4;
	assign yin[5] = y_5;

	// advance a stage when empty or when the one after it advances
	always_comb begin
		en[NST-1] = ~valid_q[NST-1] | result_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			en[i] = ~valid_q[i] | en[i+1];
		end
	end

	assign item_ready   = en[0];
	assign result_valid = valid_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (en[i]) begin
					valid_q[i] <= (i == 0) ? item_valid : valid_q[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	// lanes
	logic signed [SW-1:0]   x_s1  [L];
	logic signed [SW-1:0]   y_s1  [L];
	logic signed [2*SW-1:0] xy_s1 [L];
	logic signed [2*SW-1:0] xx_s1 [L];
	logic signed [2*SW-1:0] yy_s1 [L];

	for (genvar g = 0; g < L; g++) begin : g_lane
		pcc_lane #(.SW(SW)) u_lane (
			.clk   (clk),
			.en    (en[0]),
			.x     (xin[g]),
			.y     (yin[g]),
			.x_s1  (x_s1[g]),
			.y_s1  (y_s1[g]),
			.xy_s1 (xy_s1[g]),
			.xx_s1 (xx_s1[g]),
			.yy_s1 (yy_s1[g])
		);
	end

	// merge: sum the lane results
	logic signed [SXW-1:0] sx_c, sy_c, sx_s2, sy_s2;
	logic signed [PRW-1:0] sxy_c, sxx_c, syy_c, sxy_s2, sxx_s2, syy_s2;

	always_comb begin
		sx_c  = '0;
		sy_c  = '0;
		sxy_c = '0;
		sxx_c = '0;
		syy_c = '0;
		for (int i = 0; i < L; i++) begin
			sx_c  = sx_c  + SXW'(x_s1[i]);
			sy_c  = sy_c  + SXW'(y_s1[i]);
			sxy_c = sxy_c + PRW'(xy_s1[i]);
			sxx_c = sxx_c + PRW'(xx_s1[i]);
			syy_c = syy_c + PRW'(yy_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sx_s2  <= sx_c;
			sy_s2  <= sy_c;
			sxy_s2 <= sxy_c;
			sxx_s2 <= sxx_c;
			syy_s2 <= syy_c;
		end
	end

	// covariance and variance terms
	logic signed [NW-1:0] num_c, vx_c, vy_c;
	logic        [NW-1:0] mag_s3, vx_s3, vy_s3;
	pcc_flags_t           f_s3, f_s4, f_s5;

	assign num_c = N_S * NW'(sxy_s2) - NW'(sx_s2) * NW'(sy_s2);
	assign vx_c  = N_S * NW'(sxx_s2) - NW'(sx_s2) * NW'(sx_s2);
	assign vy_c  = N_S * NW'(syy_s2) - NW'(sy_s2) * NW'(sy_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mag_s3  <= num_c[NW-1] ? NW'(-num_c) : NW'(num_c);
			vx_s3   <= vx_c;
			vy_s3   <= vy_c;
			f_s3.neg <= num_c[NW-1];
			f_s3.deg <= (vx_c <= 0) || (vy_c <= 0);
		end
	end

	// wide products: P = vx*vy, num^2
	logic [PW-1:0] pv_s5, mm_s5;

	pcc_wide_mul #(.W(NW)) u_mul_var (
		.clk  (clk),
		.en1  (en[3]),
		.en2  (en[4]),
		.a    (vx_s3),
		.b    (vy_s3),
		.p_s2 (pv_s5)
	);

	pcc_wide_mul #(.W(NW)) u_mul_num (
		.clk  (clk),
		.en1  (en[3]),
		.en2  (en[4]),
		.a    (mag_s3),
		.b    (mag_s3),
		.p_s2 (mm_s5)
	);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			f_s4 <= f_s3;
		end
		if (en[4]) begin
			f_s5 <= f_s4;
		end
	end

	// root chain, most significant bit first
	logic [RW-1:0] r_ch [QB+1];
	logic [RW-1:0] a_ch [QB+1];
	logic [PW-1:0] p_ch [QB+1];
	logic [QB-1:0] q_ch [QB+1];
	pcc_flags_t    f_ch [QB+1];

	assign r_ch[0] = RW'(mm_s5) << FRAC_BITS * 2;
	assign a_ch[0] = '0;
	assign p_ch[0] = pv_s5;
	assign q_ch[0] = '0;
	assign f_ch[0] = f_s5;

	for (genvar j = 0; j < QB; j++) begin : g_root
		pcc_root_step #(.PW(PW), .RW(RW), .K(QB - 1 - j)) u_step (
			.clk (clk),
			.en  (en[5+j]),
			.r_i (r_ch[j]),
			.a_i (a_ch[j]),
			.p_i (p_ch[j]),
			.q_i (q_ch[j]),
			.f_i (f_ch[j]),
			.r_q (r_ch[j+1]),
			.a_q (a_ch[j+1]),
			.p_q (p_ch[j+1]),
			.q_q (q_ch[j+1]),
			.f_q (f_ch[j+1])
		);
	end

	// apply sign, force zero on a flat vector
	logic [COEF_W-1:0] qmag;

	assign qmag        = COEF_W'(q_ch[QB]);
	assign degenerate  = f_ch[QB].deg;
	assign coefficient = f_ch[QB].deg ? '0 : (f_ch[QB].neg ? $signed(-qmag) : $signed(qmag));

endmodule
